// ----- rtl/sorted_hash_table_lookup_macros.svh -----
// Assertion macros shared by the sorted hash table lookup RTL.
`ifndef SORTED_HASH_TABLE_LOOKUP_MACROS_SVH
`define SORTED_HASH_TABLE_LOOKUP_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SHTL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorted hash table lookup: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SHTL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted hash table lookup: next-cycle check failed");

`endif

// ----- rtl/shtl_pkg.sv -----
// Types, constants and codes shared by the sorted hash table lookup block.
package shtl_pkg;

   localparam int MAX_ENTRIES    = 1024;
   localparam int MAX_TEXT_BYTES = 1048576;
   localparam int SLOT_W         = $clog2(MAX_ENTRIES);
   localparam int COUNT_W        = SLOT_W + 1;
   localparam int TEXT_W         = 21;
   localparam int KEY_W          = 64;
   localparam int ID_W           = 32;
   localparam int STATUS_W       = 4;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 21;

   // Commands on the request channel.
   localparam logic [1:0] CMD_LOAD    = 2'd0;
   localparam logic [1:0] CMD_LOOKUP  = 2'd1;
   localparam logic [1:0] CMD_RESOLVE = 2'd2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_ENTRY_CAPACITY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TEXT_CAPACITY  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TEXT_SIZE      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LOCALE_VALID   = 2'd3;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK        = 4'd0;
   localparam logic [STATUS_W-1:0] ST_CAPACITY  = 4'd1;
   localparam logic [STATUS_W-1:0] ST_LOCALE    = 4'd2;
   localparam logic [STATUS_W-1:0] ST_DATA      = 4'd3;
   localparam logic [STATUS_W-1:0] ST_UNSORTED  = 4'd4;
   localparam logic [STATUS_W-1:0] ST_RANGE     = 4'd5;
   localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 4'd6;
   localparam logic [STATUS_W-1:0] ST_BAD_ID    = 4'd7;
   localparam logic [STATUS_W-1:0] ST_MISSING   = 4'd8;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 4'd9;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_LOOKUP,
      OP_RESOLVE,
      OP_BAD
   } op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SEARCH,
      S_FINAL,
      S_FETCH
   } back_state_type;

   typedef struct packed {
      logic [COUNT_W-1:0] entry_capacity;
      logic [TEXT_W-1:0]  text_capacity;
      logic [TEXT_W-1:0]  text_size;
      logic               locale_valid;
   } cfg_type;

   typedef struct packed {
      op_type            op;
      logic [KEY_W-1:0]  key_hash;
      logic [TEXT_W-1:0] text_offset;
      logic [TEXT_W-1:0] text_length;
      logic              present;
      logic              last;
      logic [ID_W-1:0]   id_identity;
      logic [SLOT_W-1:0] id_slot;
   } item_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key_hash;
      logic [TEXT_W-1:0] text_offset;
      logic [TEXT_W-1:0] text_length;
      logic              present;
   } entry_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     out_identity;
      logic [SLOT_W-1:0]   out_slot;
      logic [KEY_W-1:0]    out_key_hash;
      logic                out_present;
      logic [TEXT_W-1:0]   out_offset;
      logic [TEXT_W-1:0]   out_length;
   } rsp_type;

endpackage

// ----- rtl/shtl_req_if.sv -----
// Request channel: one load, lookup or resolve command per transaction.
interface shtl_req_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        cmd;
   logic [shtl_pkg::KEY_W-1:0]        key_hash;
   logic [shtl_pkg::TEXT_W-1:0]       text_offset;
   logic [shtl_pkg::TEXT_W-1:0]       text_length;
   logic                              present;
   logic                              last;
   logic [shtl_pkg::ID_W-1:0]         id_identity;
   logic [shtl_pkg::SLOT_W-1:0]       id_slot;

   modport source(output valid, cmd, key_hash, text_offset, text_length, present, last,
                  id_identity, id_slot, input ready);
   modport sink(input valid, cmd, key_hash, text_offset, text_length, present, last,
                id_identity, id_slot, output ready);
endinterface

// ----- rtl/shtl_rsp_if.sv -----
// Response channel: one result per request transaction.
interface shtl_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [shtl_pkg::STATUS_W-1:0]     status;
   logic [shtl_pkg::ID_W-1:0]         out_identity;
   logic [shtl_pkg::SLOT_W-1:0]       out_slot;
   logic [shtl_pkg::KEY_W-1:0]        out_key_hash;
   logic                              out_present;
   logic [shtl_pkg::TEXT_W-1:0]       out_offset;
   logic [shtl_pkg::TEXT_W-1:0]       out_length;

   modport source(output valid, status, out_identity, out_slot, out_key_hash, out_present,
                  out_offset, out_length, input ready);
   modport sink(input valid, status, out_identity, out_slot, out_key_hash, out_present,
                out_offset, out_length, output ready);
endinterface

// ----- rtl/shtl_csr_if.sv -----
// Configuration write channel: register index and write data.
interface shtl_csr_if;
   logic                                valid;
   logic                                ready;
   logic [shtl_pkg::CSR_IDX_W-1:0]      index;
   logic [shtl_pkg::CSR_DATA_W-1:0]     data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/shtl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module shtl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- rtl/shtl_front.sv -----
// Front end: configuration registers, request decode and a two-entry command queue.
module shtl_front (
   input  logic                clock,
   input  logic                reset,
   shtl_req_if.sink            req,
   shtl_csr_if.sink            csr,
   output shtl_pkg::cfg_type   cfg,
   output logic                item_valid,
   input  logic                item_ready,
   output shtl_pkg::item_type  item
);
   shtl_pkg::cfg_type  cfg_ff, cfg_in;
   shtl_pkg::item_type q_ff [2];
   shtl_pkg::item_type new_item;
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         fill_ff, fill_in;
   logic               push, pop;

   assign csr.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (csr.index)
            shtl_pkg::REG_ENTRY_CAPACITY: begin
               cfg_in.entry_capacity = csr.data[shtl_pkg::COUNT_W-1:0];
            end
            shtl_pkg::REG_TEXT_CAPACITY: begin
               cfg_in.text_capacity = csr.data[shtl_pkg::TEXT_W-1:0];
            end
            shtl_pkg::REG_TEXT_SIZE: begin
               cfg_in.text_size = csr.data[shtl_pkg::TEXT_W-1:0];
            end
            shtl_pkg::REG_LOCALE_VALID: begin
               cfg_in.locale_valid = csr.data[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   // Classify the command; an unknown command is passed on to the back end as OP_BAD.
   always_comb begin
      new_item.key_hash    = req.key_hash;
      new_item.text_offset = req.text_offset;
      new_item.text_length = req.text_length;
      new_item.present     = req.present;
      new_item.last        = req.last;
      new_item.id_identity = req.id_identity;
      new_item.id_slot     = req.id_slot;
      unique case (req.cmd)
         shtl_pkg::CMD_LOAD:    new_item.op = shtl_pkg::OP_LOAD;
         shtl_pkg::CMD_LOOKUP:  new_item.op = shtl_pkg::OP_LOOKUP;
         shtl_pkg::CMD_RESOLVE: new_item.op = shtl_pkg::OP_RESOLVE;
         default:               new_item.op = shtl_pkg::OP_BAD;
      endcase
   end

   assign req.ready  = (fill_ff != 2'd2);
   assign push       = req.valid && req.ready;
   assign item_valid = (fill_ff != 2'd0);
   assign pop        = item_valid && item_ready;
   assign item       = q_ff[rd_ptr_ff];
   assign cfg        = cfg_ff;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.entry_capacity <= shtl_pkg::COUNT_W'(shtl_pkg::MAX_ENTRIES);
         cfg_ff.text_capacity  <= shtl_pkg::TEXT_W'(shtl_pkg::MAX_TEXT_BYTES);
         cfg_ff.text_size      <= '0;
         cfg_ff.locale_valid   <= 1'b0;
         wr_ptr_ff             <= 1'b0;
         rd_ptr_ff             <= 1'b0;
         fill_ff               <= 2'd0;
      end else begin
         cfg_ff    <= cfg_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= new_item;
      end
   end
endmodule

// ----- rtl/shtl_back.sv -----
// Back end: table loading, binary-search lookup, id resolve and the result register.
module shtl_back (
   input  logic                clock,
   input  logic                reset,
   input  shtl_pkg::cfg_type   cfg,
   input  logic                item_valid,
   output logic                item_ready,
   input  shtl_pkg::item_type  item,
   shtl_rsp_if.source          rsp
);
   localparam int CW = shtl_pkg::COUNT_W;
   localparam int SW = shtl_pkg::SLOT_W;
   localparam logic [CW-1:0] MAX_CNT = CW'(shtl_pkg::MAX_ENTRIES);
   localparam logic [CW-1:0] SAT_CNT = {CW{1'b1}};

   shtl_pkg::back_state_type state_ff, state_in;
   shtl_pkg::item_type       cur_ff, cur_in;
   shtl_pkg::rsp_type        rsp_ff, rsp_in;
   shtl_pkg::entry_type      rd_entry, wr_entry;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]            lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [63:0]              prev_ff, prev_in;
   logic                     active_ff, active_in;
   logic [3:0]               err_ff, err_in;
   logic [31:0]              cur_id_ff, cur_id_in;
   logic [32:0]              next_id_ff, next_id_in;

   logic                     out_free;
   logic                     ram_we;
   logic [SW-1:0]            ram_raddr, ram_waddr;
   logic [$bits(shtl_pkg::entry_type)-1:0] ram_rdata;

   logic                     search_less, srch_more, start_more;
   logic [CW-1:0]            srch_lo, srch_hi, srch_mid, start_hi, start_mid;
   logic                     resolve_bad, final_hit, lookup_go, resolve_go;
   logic                     starting;
   logic [CW-1:0]            eff_count;
   logic [3:0]               eff_err, chk_err, new_err;
   logic [63:0]              eff_prev;
   logic                     cfg_bad;

   shtl_ram #(
      .WIDTH($bits(shtl_pkg::entry_type)),
      .DEPTH(shtl_pkg::MAX_ENTRIES)
   ) u_store (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(wr_entry),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign rd_entry = shtl_pkg::entry_type'(ram_rdata);
   assign out_free = !rsp_valid_ff || rsp.ready;

   // One step of the search: halve [lo, hi) around the entry read at mid.
   assign search_less = rd_entry.key_hash < cur_ff.key_hash;
   assign srch_lo     = search_less ? mid_ff + CW'(1) : lo_ff;
   assign srch_hi     = search_less ? hi_ff : mid_ff;
   assign srch_mid    = CW'(({1'b0, srch_lo} + {1'b0, srch_hi}) >> 1);
   assign srch_more   = srch_lo < srch_hi;
   assign start_hi    = (count_ff > MAX_CNT) ? MAX_CNT : count_ff;
   assign start_mid   = start_hi >> 1;
   assign start_more  = start_hi != '0;
   assign final_hit   = (lo_ff < count_ff) && (lo_ff < MAX_CNT)
                        && (rd_entry.key_hash == cur_ff.key_hash);
   assign resolve_bad = (cur_id_ff == '0) || (cur_ff.id_identity == '0)
                        || (cur_ff.id_identity != cur_id_ff)
                        || ({1'b0, cur_ff.id_slot} >= count_ff);
   assign lookup_go   = (cur_ff.op == shtl_pkg::OP_LOOKUP) && (cur_id_ff != '0);
   assign resolve_go  = (cur_ff.op == shtl_pkg::OP_RESOLVE) && !resolve_bad;

   // Load checks; a load that starts fresh sees cleared load state.
   assign starting  = !active_ff;
   assign eff_count = starting ? '0 : count_ff;
   assign eff_err   = starting ? '0 : err_ff;
   assign eff_prev  = starting ? '0 : prev_ff;
   assign cfg_bad   = (cfg.entry_capacity == '0) || (cfg.entry_capacity > MAX_CNT)
                      || (cfg.text_capacity > shtl_pkg::TEXT_W'(shtl_pkg::MAX_TEXT_BYTES))
                      || (cfg.text_size > cfg.text_capacity);

   always_comb begin
      if (cfg_bad) begin
         chk_err = shtl_pkg::ST_CAPACITY;
      end else if (!cfg.locale_valid) begin
         chk_err = shtl_pkg::ST_LOCALE;
      end else if (eff_count >= cfg.entry_capacity) begin
         chk_err = shtl_pkg::ST_CAPACITY;
      end else if ((eff_count != '0) && (cur_ff.key_hash <= eff_prev)) begin
         chk_err = shtl_pkg::ST_UNSORTED;
      end else if (!cur_ff.present) begin
         chk_err = (cur_ff.text_length != '0) ? shtl_pkg::ST_RANGE : shtl_pkg::ST_OK;
      end else if ((cur_ff.text_offset > cfg.text_size)
                   || (cur_ff.text_length > (cfg.text_size - cur_ff.text_offset))) begin
         chk_err = shtl_pkg::ST_RANGE;
      end else begin
         chk_err = shtl_pkg::ST_OK;
      end
   end

   assign new_err = (eff_err != '0) ? eff_err : chk_err;

   always_comb begin
      wr_entry.key_hash    = cur_ff.key_hash;
      wr_entry.present     = cur_ff.present;
      wr_entry.text_offset = cur_ff.present ? cur_ff.text_offset : '0;
      wr_entry.text_length = cur_ff.present ? cur_ff.text_length : '0;
   end
   assign ram_waddr = eff_count[SW-1:0];
   assign ram_we    = (state_ff == shtl_pkg::S_EXEC) && (cur_ff.op == shtl_pkg::OP_LOAD)
                      && out_free && (new_err == '0) && (eff_count < MAX_CNT);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         shtl_pkg::S_IDLE: begin
            if (item_valid) begin
               state_in = shtl_pkg::S_EXEC;
            end
         end
         shtl_pkg::S_EXEC: begin
            if (lookup_go) begin
               state_in = start_more ? shtl_pkg::S_SEARCH : shtl_pkg::S_FINAL;
            end else if (resolve_go) begin
               state_in = shtl_pkg::S_FETCH;
            end else if (out_free) begin
               state_in = shtl_pkg::S_IDLE;
            end
         end
         shtl_pkg::S_SEARCH: begin
            state_in = srch_more ? shtl_pkg::S_SEARCH : shtl_pkg::S_FINAL;
         end
         shtl_pkg::S_FINAL, shtl_pkg::S_FETCH: begin
            if (out_free) begin
               state_in = shtl_pkg::S_IDLE;
            end
         end
         default: state_in = shtl_pkg::S_IDLE;
      endcase
   end

   // Datapath and result register.
   always_comb begin
      item_ready   = 1'b0;
      cur_in       = cur_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      count_in     = count_ff;
      prev_in      = prev_ff;
      active_in    = active_ff;
      err_in       = err_ff;
      cur_id_in    = cur_id_ff;
      next_id_in   = next_id_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_in       = rsp_ff;
      ram_raddr    = lo_ff[SW-1:0];
      unique case (state_ff)
         shtl_pkg::S_IDLE: begin
            item_ready = 1'b1;
            if (item_valid) begin
               cur_in = item;
            end
         end
         shtl_pkg::S_EXEC: begin
            if (lookup_go) begin
               lo_in     = '0;
               hi_in     = start_hi;
               mid_in    = start_mid;
               ram_raddr = start_mid[SW-1:0];
            end else if (resolve_go) begin
               ram_raddr = cur_ff.id_slot;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               unique case (cur_ff.op)
                  shtl_pkg::OP_LOAD: begin
                     err_in    = new_err;
                     prev_in   = cur_ff.key_hash;
                     count_in  = (eff_count != SAT_CNT) ? eff_count + CW'(1) : eff_count;
                     if (starting) begin
                        cur_id_in = '0;
                     end
                     rsp_in.status = new_err;
                     active_in     = !cur_ff.last;
                     if (cur_ff.last && (new_err == '0)) begin
                        if (next_id_ff[32]) begin
                           rsp_in.status = shtl_pkg::ST_EXHAUSTED;
                        end else begin
                           cur_id_in           = next_id_ff[31:0];
                           next_id_in          = next_id_ff + 33'd1;
                           rsp_in.out_identity = next_id_ff[31:0];
                        end
                     end
                  end
                  shtl_pkg::OP_LOOKUP:  rsp_in.status = shtl_pkg::ST_NOT_FOUND;
                  shtl_pkg::OP_RESOLVE: rsp_in.status = shtl_pkg::ST_BAD_ID;
                  default:              rsp_in.status = shtl_pkg::ST_DATA;
               endcase
            end
         end
         shtl_pkg::S_SEARCH: begin
            lo_in     = srch_lo;
            hi_in     = srch_hi;
            mid_in    = srch_mid;
            ram_raddr = srch_more ? srch_mid[SW-1:0] : srch_lo[SW-1:0];
         end
         shtl_pkg::S_FINAL: begin
            ram_raddr = lo_ff[SW-1:0];
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               if (final_hit) begin
                  rsp_in.out_identity = cur_id_ff;
                  rsp_in.out_slot     = lo_ff[SW-1:0];
               end else begin
                  rsp_in.status = shtl_pkg::ST_NOT_FOUND;
               end
            end
         end
         shtl_pkg::S_FETCH: begin
            ram_raddr = cur_ff.id_slot;
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in              = '0;
               rsp_in.out_identity = cur_id_ff;
               rsp_in.out_slot     = cur_ff.id_slot;
               rsp_in.out_key_hash = rd_entry.key_hash;
               if (rd_entry.present) begin
                  rsp_in.out_present = 1'b1;
                  rsp_in.out_offset  = rd_entry.text_offset;
                  rsp_in.out_length  = rd_entry.text_length;
               end else begin
                  rsp_in.status = shtl_pkg::ST_MISSING;
               end
            end
         end
         default: begin
            item_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= shtl_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         prev_ff      <= '0;
         active_ff    <= 1'b0;
         err_ff       <= '0;
         cur_id_ff    <= '0;
         next_id_ff   <= 33'd1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         prev_ff      <= prev_in;
         active_ff    <= active_in;
         err_ff       <= err_in;
         cur_id_ff    <= cur_id_in;
         next_id_ff   <= next_id_in;
      end
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      mid_ff <= mid_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_ff.status;
   assign rsp.out_identity = rsp_ff.out_identity;
   assign rsp.out_slot     = rsp_ff.out_slot;
   assign rsp.out_key_hash = rsp_ff.out_key_hash;
   assign rsp.out_present  = rsp_ff.out_present;
   assign rsp.out_offset   = rsp_ff.out_offset;
   assign rsp.out_length   = rsp_ff.out_length;
endmodule

// ----- rtl/sorted_hash_table_lookup.sv -----
// Sorted key-hash table: entries are loaded one transaction at a time, a lookup
// binary-searches the committed table and a resolve returns one slot. The front
// end queues up to two request transactions while the back end works; the back
// end handles one command at a time. A load entry, an unknown command, a lookup
// with no committed table and a resolve of a bad id pass through the idle and
// execute states in the back end, a resolve of a good id also through the fetch
// state. A lookup runs through idle, execute, the search state once per step and
// final, with at most ceil(log2(n+1)) steps for a table of n entries, each set
// by one dependent read of the entry memory. A result that waits in the output
// register holds the back end until the receiver takes it.
`include "sorted_hash_table_lookup_macros.svh"

module sorted_hash_table_lookup (
   input logic         clock,
   input logic         reset,
   shtl_req_if.sink    req_ch,
   shtl_rsp_if.source  rsp_ch,
   shtl_csr_if.sink    csr_ch
);
   shtl_pkg::cfg_type  cfg;
   shtl_pkg::item_type item;
   logic               item_valid;
   logic               item_ready;

   shtl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .csr       (csr_ch),
      .cfg       (cfg),
      .item_valid(item_valid),
      .item_ready(item_ready),
      .item      (item)
   );

   shtl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .item_valid(item_valid),
      .item_ready(item_ready),
      .item      (item),
      .rsp       (rsp_ch)
   );

   // Resolved text always belongs to a committed table.
   `SHTL_ASSERT_NOW(a_present_has_identity, clock, reset, rsp_ch.valid && rsp_ch.out_present, rsp_ch.out_identity != '0)
   // Status codes never run past the last defined code.
   `SHTL_ASSERT_NOW(a_status_range, clock, reset, rsp_ch.valid, rsp_ch.status <= shtl_pkg::ST_NOT_FOUND)
   // Text fields are only reported for a present slot of a successful resolve.
   `SHTL_ASSERT_NOW(a_present_ok, clock, reset, rsp_ch.valid && rsp_ch.out_present, rsp_ch.status == shtl_pkg::ST_OK)
   // The back end takes a new command only after it has returned to idle.
   `SHTL_ASSERT_NEXT(a_one_in_flight, clock, reset, item_valid && item_ready, !item_ready)
endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for the sorted hash table lookup block.
`timescale 1ns / 1ps

class table_scoreboard;
   bit [shtl_pkg::KEY_W-1:0]      key_mem[shtl_pkg::MAX_ENTRIES];
   bit [shtl_pkg::TEXT_W-1:0]     offset_mem[shtl_pkg::MAX_ENTRIES];
   bit [shtl_pkg::TEXT_W-1:0]     length_mem[shtl_pkg::MAX_ENTRIES];
   bit                            present_mem[shtl_pkg::MAX_ENTRIES];
   int unsigned                   count = 0;
   bit [shtl_pkg::KEY_W-1:0]      prev_key = '0;
   bit                            loading = 0;
   logic [shtl_pkg::STATUS_W-1:0] load_status = shtl_pkg::ST_OK;
   bit [shtl_pkg::ID_W-1:0]       cur_id = '0;
   bit [shtl_pkg::ID_W:0]         next_id = 1;
   int unsigned                   entry_cap = 1024;
   int unsigned                   text_cap = 1048576;
   int unsigned                   text_sz = 0;
   bit                            locale_ok = 0;
   shtl_pkg::rsp_type             pending_q[$];
   int                            errors = 0;

   function void write_reg(logic [shtl_pkg::CSR_IDX_W-1:0] idx,
                           logic [shtl_pkg::CSR_DATA_W-1:0] val);
      case (idx)
         shtl_pkg::REG_ENTRY_CAPACITY: entry_cap = 32'(val[10:0]);
         shtl_pkg::REG_TEXT_CAPACITY:  text_cap = 32'(val);
         shtl_pkg::REG_TEXT_SIZE:      text_sz = 32'(val);
         shtl_pkg::REG_LOCALE_VALID:   locale_ok = val[0];
         default: ;
      endcase
   endfunction

   function logic [shtl_pkg::STATUS_W-1:0] entry_fault(shtl_pkg::item_type it);
      int unsigned off, len;
      off = 32'(it.text_offset);
      len = 32'(it.text_length);
      if (entry_cap == 0 || entry_cap > shtl_pkg::MAX_ENTRIES) return shtl_pkg::ST_CAPACITY;
      if (text_cap > shtl_pkg::MAX_TEXT_BYTES || text_sz > text_cap)
         return shtl_pkg::ST_CAPACITY;
      if (!locale_ok) return shtl_pkg::ST_LOCALE;
      if (count >= entry_cap) return shtl_pkg::ST_CAPACITY;
      if (count != 0 && it.key_hash <= prev_key) return shtl_pkg::ST_UNSORTED;
      if (!it.present) return (len != 0) ? shtl_pkg::ST_RANGE : shtl_pkg::ST_OK;
      if (off > text_sz || len > text_sz - off) return shtl_pkg::ST_RANGE;
      return shtl_pkg::ST_OK;
   endfunction

   // Predicts the result of one accepted transaction and queues it.
   function void note_request(shtl_pkg::item_type it);
      shtl_pkg::rsp_type r;
      logic [shtl_pkg::STATUS_W-1:0] err;
      int unsigned lo, hi, mid;
      r = '0;
      case (it.op)
         shtl_pkg::OP_LOAD: begin
            if (!loading) begin
               loading = 1;
               load_status = shtl_pkg::ST_OK;
               count = 0;
               prev_key = '0;
               cur_id = '0;
            end
            err = entry_fault(it);
            if (load_status == shtl_pkg::ST_OK && err != shtl_pkg::ST_OK) load_status = err;
            if (load_status == shtl_pkg::ST_OK && count < shtl_pkg::MAX_ENTRIES) begin
               key_mem[count] = it.key_hash;
               offset_mem[count] = it.present ? it.text_offset : '0;
               length_mem[count] = it.present ? it.text_length : '0;
               present_mem[count] = it.present;
            end
            if (count < 2047) count++;
            prev_key = it.key_hash;
            if (!it.last) begin
               r.status = load_status;
            end else begin
               loading = 0;
               if (load_status != shtl_pkg::ST_OK) begin
                  r.status = load_status;
               end else if (next_id > 33'hFFFF_FFFF) begin
                  r.status = shtl_pkg::ST_EXHAUSTED;
               end else begin
                  cur_id = next_id[shtl_pkg::ID_W-1:0];
                  next_id++;
                  r.out_identity = cur_id;
               end
            end
         end
         shtl_pkg::OP_LOOKUP: begin
            lo = 0;
            hi = (count > shtl_pkg::MAX_ENTRIES) ? shtl_pkg::MAX_ENTRIES : count;
            if (cur_id == 0) begin
               r.status = shtl_pkg::ST_NOT_FOUND;
            end else begin
               while (lo < hi) begin
                  mid = lo + (hi - lo) / 2;
                  if (key_mem[mid] < it.key_hash) lo = mid + 1;
                  else hi = mid;
               end
               if (lo >= count || lo >= shtl_pkg::MAX_ENTRIES || key_mem[lo] != it.key_hash)
               begin
                  r.status = shtl_pkg::ST_NOT_FOUND;
               end else begin
                  r.out_identity = cur_id;
                  r.out_slot = shtl_pkg::SLOT_W'(lo);
               end
            end
         end
         shtl_pkg::OP_RESOLVE: begin
            if (cur_id == 0 || it.id_identity == 0 || it.id_identity != cur_id
                  || it.id_slot >= count) begin
               r.status = shtl_pkg::ST_BAD_ID;
            end else begin
               r.out_identity = cur_id;
               r.out_slot = it.id_slot;
               r.out_key_hash = key_mem[it.id_slot];
               if (!present_mem[it.id_slot]) begin
                  r.status = shtl_pkg::ST_MISSING;
               end else begin
                  r.out_present = 1'b1;
                  r.out_offset = offset_mem[it.id_slot];
                  r.out_length = length_mem[it.id_slot];
               end
            end
         end
         default: r.status = shtl_pkg::ST_DATA;
      endcase
      pending_q.insert(pending_q.size(), r);
   endfunction

   function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_v, act_v);
      end
   endfunction

   function void check_result(shtl_pkg::rsp_type got);
      shtl_pkg::rsp_type e;
      if (pending_q.size() == 0) begin
         errors++;
         $display("%0t: result with no transaction pending, actual %h", $realtime, got);
         return;
      end
      e = pending_q.pop_front();
      compare_field("status", 64'(e.status), 64'(got.status));
      compare_field("out_identity", 64'(e.out_identity), 64'(got.out_identity));
      compare_field("out_slot", 64'(e.out_slot), 64'(got.out_slot));
      compare_field("out_key_hash", e.out_key_hash, got.out_key_hash);
      compare_field("out_present", 64'(e.out_present), 64'(got.out_present));
      compare_field("out_offset", 64'(e.out_offset), 64'(got.out_offset));
      compare_field("out_length", 64'(e.out_length), 64'(got.out_length));
   endfunction
endclass

module tb_top;
   logic clock = 0;
   logic reset;

   shtl_req_if req_ch();
   shtl_rsp_if rsp_ch();
   shtl_csr_if csr_ch();

   sorted_hash_table_lookup dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   table_scoreboard table_sb = new();
   int   sent_count = 0;
   bit   hold_rsp = 0;
   bit   no_gaps = 0;
   int   idle_cycles = 0;
   bit [shtl_pkg::KEY_W-1:0] loaded_keys[$];

   always #1 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic bit [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // Unused fields carry random values so that every input bit toggles.
   function automatic shtl_pkg::item_type noise_item(shtl_pkg::op_type op);
      shtl_pkg::item_type it;
      it.op = op;
      it.key_hash = rand64();
      it.text_offset = shtl_pkg::TEXT_W'($urandom());
      it.text_length = shtl_pkg::TEXT_W'($urandom());
      it.present = 1'($urandom());
      it.last = 1'($urandom());
      it.id_identity = $urandom();
      it.id_slot = shtl_pkg::SLOT_W'($urandom());
      return it;
   endfunction

   task automatic send(shtl_pkg::item_type it);
      int gap;
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd <= it.op;
      req_ch.key_hash <= it.key_hash;
      req_ch.text_offset <= it.text_offset;
      req_ch.text_length <= it.text_length;
      req_ch.present <= it.present;
      req_ch.last <= it.last;
      req_ch.id_identity <= it.id_identity;
      req_ch.id_slot <= it.id_slot;
      do @(posedge clock); while (!req_ch.ready);
      table_sb.note_request(it);
      sent_count++;
   endtask

   task automatic send_load(bit [63:0] key, int unsigned off, int unsigned len, bit pres,
                            bit last);
      shtl_pkg::item_type it;
      it = noise_item(shtl_pkg::OP_LOAD);
      it.key_hash = key;
      it.text_offset = shtl_pkg::TEXT_W'(off);
      it.text_length = shtl_pkg::TEXT_W'(len);
      it.present = pres;
      it.last = last;
      send(it);
   endtask

   task automatic send_lookup(bit [63:0] key);
      shtl_pkg::item_type it;
      it = noise_item(shtl_pkg::OP_LOOKUP);
      it.key_hash = key;
      send(it);
   endtask

   task automatic send_resolve(bit [31:0] id, bit [9:0] slot);
      shtl_pkg::item_type it;
      it = noise_item(shtl_pkg::OP_RESOLVE);
      it.id_identity = id;
      it.id_slot = slot;
      send(it);
   endtask

   // Leaves valid high; the caller drops it after the last write.
   task automatic write_reg(logic [shtl_pkg::CSR_IDX_W-1:0] idx, int unsigned val);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= shtl_pkg::CSR_DATA_W'(val);
      do @(posedge clock); while (!csr_ch.ready);
      table_sb.write_reg(idx, shtl_pkg::CSR_DATA_W'(val));
   endtask

   // Waits for every outstanding result, then lets the back end settle.
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (table_sb.pending_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_config(int unsigned cap, int unsigned tcap, int unsigned tsize,
                             bit loc);
      drain();
      write_reg(shtl_pkg::REG_ENTRY_CAPACITY, cap);
      write_reg(shtl_pkg::REG_TEXT_CAPACITY, tcap);
      write_reg(shtl_pkg::REG_TEXT_SIZE, tsize);
      write_reg(shtl_pkg::REG_LOCALE_VALID, 32'(loc));
      csr_ch.valid <= 1'b0;
   endtask

   task automatic random_config();
      int unsigned cap, tcap, tsize;
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) cap = 0;
      else if (r < 6) cap = 2047;
      else if (r < 12) cap = 1;
      else if (r < 17) cap = 1024;
      else cap = $urandom_range(2, 40);
      r = $urandom_range(0, 99);
      if (r < 80) tcap = shtl_pkg::MAX_TEXT_BYTES;
      else if (r < 90) tcap = $urandom_range(0, shtl_pkg::MAX_TEXT_BYTES);
      else if (r < 95) tcap = 21'h1FFFFF;
      else tcap = 0;
      r = $urandom_range(0, 99);
      if (r < 5 && tcap < 21'h1FFFFF) tsize = tcap + 1;
      else if (r < 20)
         tsize = (tcap > shtl_pkg::MAX_TEXT_BYTES) ? shtl_pkg::MAX_TEXT_BYTES : tcap;
      else
         tsize = $urandom_range(0, (tcap > shtl_pkg::MAX_TEXT_BYTES)
                                   ? shtl_pkg::MAX_TEXT_BYTES : tcap);
      set_config(cap, tcap, tsize, $urandom_range(0, 19) != 0);
   endtask

   // Loads n ascending keys; a corrupt load picks one entry to break on purpose.
   task automatic load_table(int n, bit corrupt);
      bit [63:0] stride, key;
      int unsigned off, len, tsize;
      int bad_at, kind;
      bit pres;
      stride = 64'hFFFF_FFFF_FFFF_FFFF / (n + 1);
      bad_at = corrupt ? $urandom_range(0, n - 1) : -1;
      kind = $urandom_range(0, 2);
      tsize = table_sb.text_sz;
      loaded_keys.delete();
      for (int i = 0; i < n; i++) begin
         key = i * stride + (rand64() % stride);
         pres = $urandom_range(0, 3) != 0;
         if (pres) begin
            off = $urandom_range(0, tsize);
            len = $urandom_range(0, tsize - off);
         end else begin
            off = $urandom() & 21'h1FFFFF;
            len = 0;
         end
         if (i == bad_at) begin
            case (kind)
               0: if (i > 0) key = loaded_keys[i - 1] - $urandom_range(0, 1);
               1: begin
                  pres = 1;
                  off = $urandom_range(0, tsize);
                  len = (tsize < 21'h1FFFFF) ? tsize - off + 1 : 0;
               end
               default: begin
                  pres = 0;
                  len = $urandom_range(1, 21'h1FFFFF);
               end
            endcase
         end
         loaded_keys.insert(loaded_keys.size(), key);
         send_load(key, off, len, pres, i == n - 1);
      end
   endtask

   task automatic query_burst(int m);
      int r;
      for (int i = 0; i < m; i++) begin
         r = $urandom_range(0, 99);
         if (r < 40 && loaded_keys.size() > 0)
            send_lookup(loaded_keys[$urandom_range(0, loaded_keys.size() - 1)]);
         else if (r < 55)
            send_lookup(rand64());
         else if (r < 85)
            send_resolve(table_sb.cur_id, 10'($urandom_range(0, table_sb.count)));
         else if (r < 95)
            send_resolve($urandom_range(0, 3) == 0 ? table_sb.cur_id : $urandom(),
                         10'($urandom()));
         else
            send(noise_item(shtl_pkg::OP_BAD));
      end
   endtask

   // Receiver: random stalls, plus one long hold-off when the sender asks for it.
   initial begin
      int stall;
      stall = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready)
            table_sb.check_result('{rsp_ch.status, rsp_ch.out_identity, rsp_ch.out_slot,
                                    rsp_ch.out_key_hash, rsp_ch.out_present,
                                    rsp_ch.out_offset, rsp_ch.out_length});
         if (hold_rsp) begin
            hold_rsp = 0;
            rsp_ch.ready <= 1'b0;
            repeat (400) @(posedge clock);
         end
         if (stall > 0) begin
            stall--;
            rsp_ch.ready <= 1'b0;
         end else if (!no_gaps && $urandom_range(0, 3) == 0) begin
            stall = pick_gap();
            rsp_ch.ready <= (stall == 0);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles in which no transaction moves on any channel.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (csr_ch.valid && csr_ch.ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= 5000) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int episode;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.cmd <= shtl_pkg::CMD_LOAD;
      req_ch.key_hash <= '0;
      req_ch.text_offset <= '0;
      req_ch.text_length <= '0;
      req_ch.present <= 1'b0;
      req_ch.last <= 1'b0;
      req_ch.id_identity <= '0;
      req_ch.id_slot <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= shtl_pkg::REG_ENTRY_CAPACITY;
      csr_ch.data <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: no table yet, locale invalid out of reset, unknown command.
      send_lookup(64'hFFFF_FFFF_FFFF_FFFF);
      send_resolve(32'd0, 10'd0);
      send_load(64'd0, 0, 0, 1, 1);
      send(noise_item(shtl_pkg::OP_BAD));
      set_config(1024, shtl_pkg::MAX_TEXT_BYTES, shtl_pkg::MAX_TEXT_BYTES, 1);
      // Extreme keys, text exactly filling the blob, an absent entry.
      send_load(64'd0, 21'h1FFFFF, 0, 0, 0);
      send_load(64'd5, 0, shtl_pkg::MAX_TEXT_BYTES, 1, 0);
      send_load(64'd6, shtl_pkg::MAX_TEXT_BYTES, 0, 1, 0);
      send_load(64'hFFFF_FFFF_FFFF_FFFF, 1, 2, 1, 1);
      send_lookup(64'd0);
      send_lookup(64'hFFFF_FFFF_FFFF_FFFF);
      send_lookup(64'd3);
      send_resolve(table_sb.cur_id, 10'd0);
      send_resolve(table_sb.cur_id, 10'd1);
      send_resolve(table_sb.cur_id, 10'd4);
      send_resolve(table_sb.cur_id + 32'd1, 10'd0);
      // Range overrun, repeated key, absent entry with a length.
      send_load(64'd1, shtl_pkg::MAX_TEXT_BYTES, 1, 1, 1);
      send_load(64'd9, 0, 0, 1, 0);
      send_load(64'd9, 0, 0, 1, 1);
      send_load(64'd1, 0, 1, 0, 1);
      // Queries while a load is in progress see no table.
      send_load(64'd1, 0, 0, 1, 0);
      send_lookup(64'd1);
      send_resolve(32'd1, 10'd0);
      send_load(64'd2, 0, 0, 0, 1);
      send_resolve(32'd1, 10'd0);
      // Register extremes.
      set_config(1, shtl_pkg::MAX_TEXT_BYTES, 0, 1);
      send_load(64'd1, 0, 0, 1, 0);
      send_load(64'd2, 0, 0, 1, 1);
      set_config(0, 0, 0, 1);
      send_load(64'd1, 0, 0, 1, 1);
      set_config(2047, 0, 0, 1);
      send_load(64'd1, 0, 0, 1, 1);
      set_config(8, 21'h1FFFFF, 0, 1);
      send_load(64'd1, 0, 0, 1, 1);
      set_config(8, 100, 101, 1);
      send_load(64'd1, 0, 0, 1, 1);
      set_config(8, 0, 0, 1);
      send_load(64'd1, 0, 0, 1, 1);
      send_resolve(table_sb.cur_id, 10'd0);

      // Random episodes: mostly clean loads followed by queries.
      episode = 0;
      while (sent_count < 700) begin
         if (episode % 4 == 0) begin
            random_config();
            no_gaps = ($urandom_range(0, 4) == 0);
         end
         if (episode % 5 == 4) drain();
         if (sent_count > 350 && episode < 1000) begin
            hold_rsp = 1;
            episode = 1000;
         end
         load_table($urandom_range(0, 9) == 0 ? $urandom_range(13, 40)
                                              : $urandom_range(1, 12),
                    $urandom_range(0, 6) == 0);
         query_burst($urandom_range(3, 12));
         episode++;
      end

      req_ch.valid <= 1'b0;
      while (table_sb.pending_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (table_sb.errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule
